// File: hdl/khc_pkg.sv
// Package for the keyed handle cache: widths, codes, shared structs.
// Used by the cache cell, the top level and the bench.
package khc_pkg;

    localparam int DEPTH  = 16;
    localparam int SLOT_W = 4;
    localparam int CNT_W  = 5;

    typedef enum logic [1:0] {
        OP_LOOKUP    = 2'd0,
        OP_LOOKUP_ADD = 2'd1,
        OP_FLUSH     = 2'd2,
        OP_CLOSE_ALL = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_HIT       = 3'd0,
        KIND_MISS      = 3'd1,
        KIND_ADDED     = 3'd2,
        KIND_EVICTED   = 3'd3,
        KIND_OPEN_FAIL = 3'd4,
        KIND_CLOSED    = 3'd5,
        KIND_DONE      = 3'd6
    } kind_t;

    localparam logic CFG_MAX_ENTRIES = 1'b0;
    localparam logic CFG_TIMEOUT     = 1'b1;

    localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 5'd16;
    localparam logic [31:0]      TIMEOUT_RST     = 32'd300000;

    typedef struct packed {
        logic [15:0] sensor;
        logic [7:0]  flowtype;
        logic [47:0] time_bin;
        logic [47:0] last_access;
    } entry_t;

    typedef struct packed {
        logic              valid;
        logic [47:0]       last_access;
        logic [SLOT_W-1:0] idx;
    } min_t;

    typedef struct packed {
        logic wr;
        logic touch;
        logic shift;
        logic eval;
        logic is_flush;
    } cell_ctl_t;

endpackage

// File: hdl/khc_if.sv
// Stream interfaces for the keyed handle cache request and result channels.
interface khc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] req_sensor;
    logic [7:0]  req_flowtype;
    logic [47:0] req_time_bin;
    logic [47:0] now_time;
    logic        open_ok;

    modport source (output valid, op, req_sensor, req_flowtype, req_time_bin, now_time,
                    open_ok, input ready);
    modport sink (input valid, op, req_sensor, req_flowtype, req_time_bin, now_time,
                  open_ok, output ready);
endinterface

interface khc_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [15:0] out_sensor;
    logic [7:0]  out_flowtype;
    logic [47:0] out_time_bin;
    logic [4:0]  occupancy;
    logic        last;

    modport source (output valid, kind, slot, out_sensor, out_flowtype, out_time_bin,
                    occupancy, last, input ready);
    modport sink (input valid, kind, slot, out_sensor, out_flowtype, out_time_bin,
                  occupancy, last, output ready);
endinterface

// File: hdl/khc_cell.sv
// One cache slot: key, access stamp, match and keep flags, and one stage of
// the oldest-entry search chain. Depends on khc_pkg.
module khc_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  khc_pkg::cell_ctl_t         ctl,
    input  khc_pkg::entry_t            req,
    input  logic [31:0]                timeout,
    input  logic                       valid,
    input  logic [khc_pkg::SLOT_W-1:0] idx,
    input  khc_pkg::entry_t            nbr,
    input  logic                       nbr_keep,
    input  khc_pkg::min_t              min_in,
    output khc_pkg::entry_t            entry,
    output logic                       keep,
    output logic                       match,
    output khc_pkg::min_t              min_out
);
    import khc_pkg::*;

    entry_t entry_reg;
    logic   keep_reg;
    logic   match_reg;
    min_t   min_reg;
    min_t   min_next;
    logic   alive;

    assign alive = ({1'b0, entry_reg.last_access} + 49'(timeout)) > {1'b0, req.last_access};

    always_comb
    begin
        min_next = min_in;
        if (valid && (!min_in.valid || entry_reg.last_access < min_in.last_access))
        begin
            min_next.valid       = 1'b1;
            min_next.last_access = entry_reg.last_access;
            min_next.idx         = idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
            entry_reg <= req;
        else if (ctl.touch)
            entry_reg.last_access <= req.last_access;
        else if (ctl.shift)
            entry_reg <= nbr;
        if (ctl.eval)
        begin
            match_reg <= entry_reg.sensor == req.sensor && entry_reg.flowtype == req.flowtype
                         && entry_reg.time_bin == req.time_bin;
            keep_reg  <= valid && ctl.is_flush && alive;
        end
        else if (ctl.shift)
            keep_reg <= nbr_keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_reg <= '0;
        else
            min_reg <= min_next;
    end

    assign entry   = entry_reg;
    assign keep    = keep_reg;
    assign match   = match_reg;
    assign min_out = min_reg;
endmodule

// File: hdl/keyed_handle_cache_lru_timeout_top.sv
// Keyed handle cache, 16 slots, one request at a time. A lookup, a hit or a plain add
// gives its result from the S_DECIDE state. An add after eviction waits in S_EVICT, because
// the oldest-entry search ripples one slot per cycle through the cell chain. A flush or a
// close-all walks the slots one by one in S_WALK. Output stalls can hold any of these.
// Depends on khc_pkg, khc_req_if, khc_res_if and khc_cell.
module keyed_handle_cache_lru_timeout_top
(
    input  logic        clk,
    input  logic        rst_n,
    khc_req_if.sink     in_ch,
    khc_res_if.source   out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import khc_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_DECIDE, S_EVICT, S_WALK} state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  max_reg;
    logic [31:0]       timeout_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  kept_reg;
    logic [CNT_W-1:0]  p_reg;
    logic [CNT_W-1:0]  o_reg;
    logic [CNT_W-1:0]  wait_reg;
    op_t               op_reg;
    logic              open_reg;
    entry_t            req_reg;

    logic              ov_reg;
    logic [2:0]        kind_reg;
    logic [3:0]        slot_reg;
    logic [15:0]       osens_reg;
    logic [7:0]        oflow_reg;
    logic [47:0]       otb_reg;
    logic [4:0]        occ_reg;
    logic              last_reg;

    cell_ctl_t         ctl   [DEPTH];
    entry_t            ent   [DEPTH];
    logic              kp    [DEPTH];
    logic              mt    [DEPTH];
    min_t              mn    [DEPTH];
    logic              vld   [DEPTH];

    logic              out_free;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  keep_cnt;
    logic              do_wr, do_touch, do_shift, do_eval;
    logic [SLOT_W-1:0] wr_idx;
    entry_t            p_ent;
    logic              p_keep;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            khc_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl[g]),
                .req      (req_reg),
                .timeout  (timeout_reg),
                .valid    (vld[g]),
                .idx      (SLOT_W'(g)),
                .nbr      ((g == DEPTH-1) ? ent[g] : ent[(g+1)%DEPTH]),
                .nbr_keep ((g == DEPTH-1) ? 1'b0 : kp[(g+1)%DEPTH]),
                .min_in   ((g == 0) ? min_t'('0) : mn[(g+DEPTH-1)%DEPTH]),
                .entry    (ent[g]),
                .keep     (kp[g]),
                .match    (mt[g]),
                .min_out  (mn[g])
            );
            assign vld[g] = CNT_W'(g) < count_reg;
            assign ctl[g] = '{wr: do_wr && wr_idx == SLOT_W'(g),
                              touch: do_touch && hit_idx == SLOT_W'(g),
                              shift: do_shift && CNT_W'(g) >= p_reg,
                              eval: do_eval,
                              is_flush: op_reg == OP_FLUSH};
        end
    endgenerate

    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        keep_cnt = '0;
        for (int i = DEPTH-1; i >= 0; i--)
        begin
            if (mt[i] && vld[i])
            begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            keep_cnt = keep_cnt + CNT_W'(kp[i]);
        end
    end

    assign lim      = (max_reg == '0) ? CNT_W'(1) : (max_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH)
                      : max_reg;
    assign out_free = !ov_reg || out_ch.ready;
    assign p_ent    = ent[p_reg[SLOT_W-1:0]];
    assign p_keep   = kp[p_reg[SLOT_W-1:0]];
    assign do_eval  = state_reg == S_EVAL;
    assign do_touch = state_reg == S_DECIDE && out_free && op_reg != OP_FLUSH
                      && op_reg != OP_CLOSE_ALL && hit;
    assign do_wr    = (state_reg == S_DECIDE && out_free && op_reg == OP_LOOKUP_ADD && !hit
                       && open_reg && count_reg < lim)
                      || (state_reg == S_EVICT && wait_reg == '0 && out_free);
    assign wr_idx   = (state_reg == S_EVICT) ? mn[DEPTH-1].idx : count_reg[SLOT_W-1:0];
    assign do_shift = state_reg == S_WALK && o_reg != count_reg && !p_keep && out_free;

    assign in_ch.ready = state_reg == S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            max_reg     <= MAX_ENTRIES_RST;
            timeout_reg <= TIMEOUT_RST;
            count_reg   <= '0;
            kept_reg    <= '0;
            p_reg       <= '0;
            o_reg       <= '0;
            wait_reg    <= '0;
            op_reg      <= OP_LOOKUP;
            open_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAX_ENTRIES)
                    max_reg <= cfg_data[CNT_W-1:0];
                else
                    timeout_reg <= cfg_data;
            end
            if (out_ch.ready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        op_reg   <= op_t'(in_ch.op);
                        open_reg <= in_ch.open_ok;
                        req_reg  <= '{sensor: in_ch.req_sensor, flowtype: in_ch.req_flowtype,
                                      time_bin: in_ch.req_time_bin,
                                      last_access: in_ch.now_time};
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                    state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    if (op_reg == OP_FLUSH || op_reg == OP_CLOSE_ALL)
                    begin
                        kept_reg  <= keep_cnt;
                        p_reg     <= '0;
                        o_reg     <= '0;
                        state_reg <= S_WALK;
                    end
                    else if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        slot_reg  <= '0;
                        osens_reg <= '0;
                        oflow_reg <= '0;
                        otb_reg   <= '0;
                        occ_reg   <= count_reg;
                        last_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                        if (hit)
                        begin
                            kind_reg <= KIND_HIT;
                            slot_reg <= hit_idx;
                        end
                        else if (op_reg == OP_LOOKUP)
                            kind_reg <= KIND_MISS;
                        else if (!open_reg)
                            kind_reg <= KIND_OPEN_FAIL;
                        else if (count_reg < lim)
                        begin
                            kind_reg  <= KIND_ADDED;
                            slot_reg  <= count_reg[SLOT_W-1:0];
                            occ_reg   <= count_reg + CNT_W'(1);
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ov_reg    <= 1'b0;
                            wait_reg  <= CNT_W'(DEPTH);
                            state_reg <= S_EVICT;
                        end
                    end
                end
                S_EVICT:
                begin
                    if (wait_reg != '0)
                        wait_reg <= wait_reg - CNT_W'(1);
                    else if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        kind_reg  <= KIND_EVICTED;
                        slot_reg  <= mn[DEPTH-1].idx;
                        osens_reg <= ent[mn[DEPTH-1].idx].sensor;
                        oflow_reg <= ent[mn[DEPTH-1].idx].flowtype;
                        otb_reg   <= ent[mn[DEPTH-1].idx].time_bin;
                        occ_reg   <= count_reg;
                        last_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_WALK:
                begin
                    if (o_reg == count_reg)
                    begin
                        if (out_free)
                        begin
                            ov_reg    <= 1'b1;
                            kind_reg  <= KIND_DONE;
                            slot_reg  <= '0;
                            osens_reg <= '0;
                            oflow_reg <= '0;
                            otb_reg   <= '0;
                            occ_reg   <= kept_reg;
                            last_reg  <= 1'b1;
                            count_reg <= kept_reg;
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (p_keep)
                    begin
                        p_reg <= p_reg + CNT_W'(1);
                        o_reg <= o_reg + CNT_W'(1);
                    end
                    else if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        kind_reg  <= KIND_CLOSED;
                        slot_reg  <= o_reg[SLOT_W-1:0];
                        osens_reg <= p_ent.sensor;
                        oflow_reg <= p_ent.flowtype;
                        otb_reg   <= p_ent.time_bin;
                        occ_reg   <= kept_reg;
                        last_reg  <= 1'b0;
                        o_reg     <= o_reg + CNT_W'(1);
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid        = ov_reg;
    assign out_ch.kind         = kind_reg;
    assign out_ch.slot         = slot_reg;
    assign out_ch.out_sensor   = osens_reg;
    assign out_ch.out_flowtype = oflow_reg;
    assign out_ch.out_time_bin = otb_reg;
    assign out_ch.occupancy    = occ_reg;
    assign out_ch.last         = last_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");
    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> p_reg <= o_reg && o_reg <= count_reg)
        else $error("compaction pointers out of order");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && kind_reg == KIND_DONE |-> last_reg)
        else $error("done result without last");
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVICT |-> count_reg != '0)
        else $error("eviction from an empty table");
endmodule

// File: verif/keyed_handle_cache_lru_timeout_top_test.sv
// Self-checking bench for the keyed handle cache: lookups, adds, LRU eviction,
// timeout flush and close-all, with a behavioral predictor and random stalls.
// Depends on khc_pkg, khc_req_if, khc_res_if and keyed_handle_cache_lru_timeout_top.
module keyed_handle_cache_lru_timeout_top_test;
    import khc_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  slot;
        logic [15:0] sensor;
        logic [7:0]  flowtype;
        logic [47:0] time_bin;
        logic [4:0]  occupancy;
        logic        last;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_MAX_ENTRIES;
    logic [31:0] cfg_data = '0;

    khc_req_if in_ch();
    khc_res_if out_ch();

    keyed_handle_cache_lru_timeout_top i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [15:0] tbl_sensor [DEPTH];
    logic [7:0]  tbl_flowtype [DEPTH];
    logic [47:0] tbl_time_bin [DEPTH];
    logic [47:0] tbl_access [DEPTH];
    int unsigned tbl_count = 0;
    logic [4:0]  lim_reg = MAX_ENTRIES_RST;
    logic [31:0] timeout_reg = TIMEOUT_RST;

    result_t expected_results[$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_cycles = 0;
    logic [47:0] clock_now = 48'd1000;

    function automatic result_t mk(kind_t k, int unsigned s, logic [15:0] se,
                                   logic [7:0] fl, logic [47:0] tb);
        result_t r;
        r = '0;
        r.kind = k;
        r.slot = s[3:0];
        r.sensor = se;
        r.flowtype = fl;
        r.time_bin = tb;
        return r;
    endfunction

    task automatic predict_cache(op_t op, logic [15:0] se, logic [7:0] fl, logic [47:0] tb,
                                 logic [47:0] now, logic ok);
        result_t res[$];
        int unsigned lim;
        int unsigned victim;
        int unsigned keep_n;
        int hit;
        hit = -1;
        if (op == OP_LOOKUP || op == OP_LOOKUP_ADD)
        begin
            for (int i = 0; i < tbl_count; i++)
                if (hit < 0 && tbl_sensor[i] == se && tbl_flowtype[i] == fl
                    && tbl_time_bin[i] == tb)
                    hit = i;
            if (hit >= 0)
            begin
                tbl_access[hit] = now;
                res.push_back(mk(KIND_HIT, hit, 0, 0, 0));
            end
            else if (op == OP_LOOKUP)
                res.push_back(mk(KIND_MISS, 0, 0, 0, 0));
            else if (!ok)
                res.push_back(mk(KIND_OPEN_FAIL, 0, 0, 0, 0));
            else
            begin
                lim = lim_reg;
                if (lim < 1) lim = 1;
                if (lim > DEPTH) lim = DEPTH;
                if (tbl_count < lim)
                begin
                    victim = tbl_count;
                    tbl_count++;
                    res.push_back(mk(KIND_ADDED, victim, 0, 0, 0));
                end
                else
                begin
                    victim = 0;
                    for (int i = 1; i < tbl_count; i++)
                        if (tbl_access[i] < tbl_access[victim])
                            victim = i;
                    res.push_back(mk(KIND_EVICTED, victim, tbl_sensor[victim],
                                     tbl_flowtype[victim], tbl_time_bin[victim]));
                end
                tbl_sensor[victim] = se;
                tbl_flowtype[victim] = fl;
                tbl_time_bin[victim] = tb;
                tbl_access[victim] = now;
            end
        end
        else
        begin
            keep_n = 0;
            for (int i = 0; i < tbl_count; i++)
            begin
                if (op == OP_FLUSH && ({1'b0, tbl_access[i]} + timeout_reg) > {1'b0, now})
                begin
                    tbl_sensor[keep_n] = tbl_sensor[i];
                    tbl_flowtype[keep_n] = tbl_flowtype[i];
                    tbl_time_bin[keep_n] = tbl_time_bin[i];
                    tbl_access[keep_n] = tbl_access[i];
                    keep_n++;
                end
                else
                    res.push_back(mk(KIND_CLOSED, i, tbl_sensor[i], tbl_flowtype[i],
                                     tbl_time_bin[i]));
            end
            tbl_count = keep_n;
            res.push_back(mk(KIND_DONE, 0, 0, 0, 0));
        end
        foreach (res[k])
        begin
            res[k].occupancy = tbl_count[4:0];
            res[k].last = (k == res.size() - 1);
            expected_results.push_back(res[k]);
        end
    endtask

    // valid stays up after the transfer until the next falling edge drive
    task automatic send_request(op_t op, logic [15:0] se, logic [7:0] fl, logic [47:0] tb,
                                logic [47:0] now, logic ok);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.req_sensor <= se;
        in_ch.req_flowtype <= fl;
        in_ch.req_time_bin <= tb;
        in_ch.now_time <= now;
        in_ch.open_ok <= ok;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_cache(op, se, fl, tb, now, ok);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_ENTRIES)
            lim_reg = val[4:0];
        else
            timeout_reg = val;
    endtask

    // keys partly from a small pool so hits and evictions are common
    task automatic send_random(int unsigned pool);
        int unsigned r;
        logic [15:0] se;
        logic [7:0] fl;
        logic [47:0] tb;
        op_t op;
        r = $urandom_range(pool - 1);
        se = (r % 3 == 0) ? 16'(r) : 16'($urandom);
        fl = 8'(r * 37);
        tb = (r % 5 == 0) ? {$urandom, $urandom} : 48'(r);
        if (r % 5 == 0) tb = 48'hFFFF_FFFF_FFFF - r;
        if (r == 1) se = 16'hFFFF;
        r = $urandom_range(99);
        if (r < 30) op = OP_LOOKUP;
        else if (r < 92) op = OP_LOOKUP_ADD;
        else if (r < 98) op = OP_FLUSH;
        else op = OP_CLOSE_ALL;
        clock_now = clock_now + $urandom_range(4000);
        send_request(op, se, fl, tb, clock_now, $urandom_range(9) != 0);
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.kind = kind_t'(out_ch.kind);
            got.slot = out_ch.slot;
            got.sensor = out_ch.out_sensor;
            got.flowtype = out_ch.out_flowtype;
            got.time_bin = out_ch.out_time_bin;
            got.occupancy = out_ch.occupancy;
            got.last = out_ch.last;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: %p", got);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p, actual %p", exp_r, got);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_directed();
        send_request(OP_FLUSH, 0, 0, 0, 48'd0, 1'b1);
        send_request(OP_LOOKUP, 16'hFFFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 48'd5, 1'b1);
        send_request(OP_LOOKUP_ADD, 16'hFFFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 48'd5, 1'b0);
        send_request(OP_LOOKUP_ADD, 16'hFFFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 48'd10, 1'b1);
        send_request(OP_LOOKUP_ADD, 16'h0, 8'h0, 48'h0, 48'd20, 1'b1);
        send_request(OP_LOOKUP, 16'hFFFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 48'd30, 1'b0);
        send_request(OP_LOOKUP_ADD, 16'h0, 8'h0, 48'h0, 48'd40, 1'b0);
        send_request(OP_LOOKUP, 16'hFFFF, 8'hFF, 48'h0, 48'd40, 1'b1);
        send_request(OP_CLOSE_ALL, 0, 0, 0, 48'd50, 1'b1);
        send_request(OP_CLOSE_ALL, 0, 0, 0, 48'd50, 1'b1);
        write_reg(CFG_MAX_ENTRIES, 32'd3);
        for (int i = 0; i < 3; i++)
            send_request(OP_LOOKUP_ADD, 16'(i), 8'(i), 48'(i), 48'd100, 1'b1);
        // equal stamps: lowest slot goes; then the last slot is oldest
        send_request(OP_LOOKUP_ADD, 16'd7, 8'd7, 48'd7, 48'd200, 1'b1);
        send_request(OP_LOOKUP, 16'd7, 8'd7, 48'd7, 48'd300, 1'b1);
        send_request(OP_LOOKUP, 16'd1, 8'd1, 48'd1, 48'd300, 1'b1);
        send_request(OP_LOOKUP_ADD, 16'd8, 8'd8, 48'd8, 48'd400, 1'b1);
        write_reg(CFG_MAX_ENTRIES, 32'd0);
        send_request(OP_LOOKUP_ADD, 16'd9, 8'd9, 48'd9, 48'd500, 1'b1);
        write_reg(CFG_TIMEOUT, 32'd150);
        send_request(OP_FLUSH, 0, 0, 0, 48'd550, 1'b1);
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        send_request(OP_FLUSH, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 1'b1);
        write_reg(CFG_TIMEOUT, 32'd0);
        send_request(OP_FLUSH, 0, 0, 0, 48'd0, 1'b1);
        write_reg(CFG_MAX_ENTRIES, 32'd31);
    endtask

    task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            send_random(24);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        hold_cycles = 400;
        for (int i = 0; i < 20; i++)
            send_random(24);
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOOKUP;
        in_ch.req_sensor = '0;
        in_ch.req_flowtype = '0;
        in_ch.req_time_bin = '0;
        in_ch.now_time = '0;
        in_ch.open_ok = 1'b0;
        out_ch.ready = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        write_reg(CFG_TIMEOUT, 32'd20000);
        test_random(80, 0, 0);
        write_reg(CFG_MAX_ENTRIES, 32'd16);
        test_random(80, 56, 0);
        write_reg(CFG_MAX_ENTRIES, 32'd5);
        write_reg(CFG_TIMEOUT, 32'd6000);
        test_random(70, 0, 56);
        write_reg(CFG_MAX_ENTRIES, 32'd1);
        test_random(40, 34, 34);
        write_reg(CFG_MAX_ENTRIES, 32'd12);
        test_backpressure();
        wait_idle();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end
endmodule
